// ===== rtl/ucrr_pkg.sv =====
// Shared types, codes and sizes for the USB control request responder.
// Used by the front decoder, the command queue, the back executor and the checker.
`default_nettype none

package ucrr_pkg;

    // Descriptor key table.
    localparam int TABLE_DEPTH = 8;
    localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Bytes sent in reply to a HID get report request.
    localparam int REPORT_BYTES = 64;

    // Command queue between the front and back parts.
    localparam int CMD_FIFO_DEPTH = 2;
    localparam int CMD_PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
    localparam int CMD_CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

    // Stream widths.
    localparam int IN_DATA_W = 80;
    localparam int IN_USER_W = 2;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USER_W = 2;

    localparam logic [6:0] ADDR_MASK = 7'h7F;

    // Input item kinds (carried in tuser).
    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_SETUP = 2'd1;
    localparam logic [1:0] FUNC_BUS_RESET = 2'd2;

    // bmRequestType bits 6:5.
    localparam logic [1:0] KIND_STANDARD = 2'd0;
    localparam logic [1:0] KIND_CLASS = 2'd1;

    // Standard bRequest codes.
    localparam logic [7:0] REQ_GET_STATUS = 8'd0;
    localparam logic [7:0] REQ_CLEAR_FEATURE = 8'd1;
    localparam logic [7:0] REQ_SET_FEATURE = 8'd3;
    localparam logic [7:0] REQ_SET_ADDRESS = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;
    localparam logic [7:0] REQ_SET_DESCRIPTOR = 8'd7;
    localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
    localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;

    // HID class bRequest codes.
    localparam logic [7:0] CLS_GET_REPORT = 8'h01;
    localparam logic [7:0] CLS_SET_REPORT = 8'h09;
    localparam logic [7:0] CLS_SET_IDLE = 8'h0A;

    // Result action codes (carried in tuser).
    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_REPLY = 2'd1;
    localparam logic [1:0] ACT_STALL = 2'd2;

    // Reply data sources.
    localparam logic [1:0] SRC_ZERO = 2'd0;
    localparam logic [1:0] SRC_DESC = 2'd1;
    localparam logic [1:0] SRC_CONFIG = 2'd2;

    // Classified operation handed from the front to the back.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_BUS_RESET,
        OP_STATUS,
        OP_GET_STATUS,
        OP_SET_ADDR,
        OP_SET_CONFIG,
        OP_GET_DESC,
        OP_GET_CONFIG,
        OP_GET_REPORT,
        OP_STALL
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t     op;
        logic [2:0]  slot;
        logic [7:0]  entry_length;
        logic [15:0] value;
        logic [15:0] index;
        logic [15:0] length;
    } cmd_t;

    typedef struct packed {
        logic [15:0] value;
        logic [15:0] index;
        logic [7:0]  length;
    } desc_key_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] len;
        logic [1:0] src;
        logic [2:0] slot;
    } result_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_DONE
    } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/ucrr_front.sv =====
// Front part: unpacks an input word and classifies it into a command.
// Depends on ucrr_pkg.
`default_nettype none

module ucrr_front (
    input  wire logic [ucrr_pkg::IN_DATA_W-1:0] in_data,
    input  wire logic [ucrr_pkg::IN_USER_W-1:0] in_user,
    output ucrr_pkg::cmd_t                      cmd
);

    logic [7:0] request_type;
    logic [7:0] request_code;
    ucrr_pkg::cmd_op_t op;

    assign request_type = in_data[18:11];
    assign request_code = in_data[26:19];

    always_comb
    begin
        op = ucrr_pkg::OP_NONE;
        case (in_user)
            ucrr_pkg::FUNC_LOAD: op = ucrr_pkg::OP_LOAD;
            ucrr_pkg::FUNC_BUS_RESET: op = ucrr_pkg::OP_BUS_RESET;
            ucrr_pkg::FUNC_SETUP:
            begin
                if (request_type[6:5] == ucrr_pkg::KIND_STANDARD)
                begin
                    case (request_code)
                        ucrr_pkg::REQ_GET_STATUS: op = ucrr_pkg::OP_GET_STATUS;
                        ucrr_pkg::REQ_CLEAR_FEATURE: op = ucrr_pkg::OP_STATUS;
                        ucrr_pkg::REQ_SET_FEATURE: op = ucrr_pkg::OP_STATUS;
                        ucrr_pkg::REQ_SET_DESCRIPTOR: op = ucrr_pkg::OP_STATUS;
                        ucrr_pkg::REQ_SET_ADDRESS: op = ucrr_pkg::OP_SET_ADDR;
                        ucrr_pkg::REQ_GET_DESCRIPTOR: op = ucrr_pkg::OP_GET_DESC;
                        ucrr_pkg::REQ_GET_CONFIGURATION: op = ucrr_pkg::OP_GET_CONFIG;
                        ucrr_pkg::REQ_SET_CONFIGURATION: op = ucrr_pkg::OP_SET_CONFIG;
                        default: op = ucrr_pkg::OP_STALL;
                    endcase
                end
                else if (request_type[6:5] == ucrr_pkg::KIND_CLASS)
                begin
                    case (request_code)
                        ucrr_pkg::CLS_GET_REPORT: op = ucrr_pkg::OP_GET_REPORT;
                        ucrr_pkg::CLS_SET_REPORT: op = ucrr_pkg::OP_STATUS;
                        ucrr_pkg::CLS_SET_IDLE: op = ucrr_pkg::OP_STATUS;
                        default: op = ucrr_pkg::OP_STALL;
                    endcase
                end
                else
                begin
                    // Vendor and reserved request types get no answer.
                    op = ucrr_pkg::OP_NONE;
                end
            end
            default: op = ucrr_pkg::OP_NONE;
        endcase
    end

    always_comb
    begin
        cmd.op = op;
        cmd.slot = in_data[2:0];
        cmd.entry_length = in_data[10:3];
        cmd.value = in_data[42:27];
        cmd.index = in_data[58:43];
        cmd.length = in_data[74:59];
    end

endmodule

`default_nettype wire

// ===== rtl/ucrr_cmd_fifo.sv =====
// Short command queue between the front decoder and the back executor.
// Depends on ucrr_pkg.
`default_nettype none

module ucrr_cmd_fifo (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  ucrr_pkg::cmd_t push_cmd,
    output logic          full,
    input  wire logic     pop,
    output ucrr_pkg::cmd_t head_cmd,
    output logic          empty
);

    ucrr_pkg::cmd_t mem [ucrr_pkg::CMD_FIFO_DEPTH];
    logic [ucrr_pkg::CMD_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ucrr_pkg::CMD_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ucrr_pkg::CMD_CNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign full = (count_reg == ucrr_pkg::CMD_CNT_W'(ucrr_pkg::CMD_FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign head_cmd = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == ucrr_pkg::CMD_FIFO_DEPTH - 1) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == ucrr_pkg::CMD_FIFO_DEPTH - 1) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ucrr_back.sv =====
// Back part: executes commands, holds the descriptor table, address and
// configuration, scans the table one slot per cycle and drives the result word.
// Depends on ucrr_pkg.
`default_nettype none

module ucrr_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  ucrr_pkg::cmd_t                    cmd,
    input  wire logic                         cmd_empty,
    output logic                              cmd_pop,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [ucrr_pkg::OUT_DATA_W-1:0]   out_data,
    output logic [ucrr_pkg::OUT_USER_W-1:0]   out_user
);

    ucrr_pkg::back_state_t state_reg, state_next;

    ucrr_pkg::desc_key_t keys_reg [ucrr_pkg::TABLE_DEPTH];
    logic [ucrr_pkg::TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic tbl_we;
    logic [ucrr_pkg::SLOT_W-1:0] tbl_slot;

    logic [6:0] addr_reg, addr_next;
    logic [7:0] cfg_reg, cfg_next;

    logic [ucrr_pkg::SLOT_W-1:0] scan_reg, scan_next;
    logic [15:0] key_value_reg, key_index_reg, key_length_reg;
    ucrr_pkg::desc_key_t scan_entry;
    logic scan_hit;
    logic scan_last;

    ucrr_pkg::result_t res_reg, res_next;

    logic out_load;
    logic out_valid_reg, out_valid_next;
    logic [ucrr_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic [ucrr_pkg::OUT_USER_W-1:0] out_user_reg;

    assign tbl_slot = ucrr_pkg::SLOT_W'(cmd.slot);
    assign scan_entry = keys_reg[scan_reg];
    assign scan_hit = valid_reg[scan_reg] && (scan_entry.value == key_value_reg)
                    && (scan_entry.index == key_index_reg);
    assign scan_last = (scan_reg == '0);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ucrr_pkg::B_IDLE:
            begin
                if (!cmd_empty)
                begin
                    state_next = (cmd.op == ucrr_pkg::OP_GET_DESC) ? ucrr_pkg::B_SCAN
                               : ucrr_pkg::B_DONE;
                end
            end
            ucrr_pkg::B_SCAN:
            begin
                if (scan_hit || scan_last)
                begin
                    state_next = ucrr_pkg::B_DONE;
                end
            end
            ucrr_pkg::B_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ucrr_pkg::B_IDLE;
                end
            end
            default: state_next = ucrr_pkg::B_IDLE;
        endcase
    end

    // Datapath controls.
    always_comb
    begin
        cmd_pop = 1'b0;
        tbl_we = 1'b0;
        addr_next = addr_reg;
        cfg_next = cfg_reg;
        scan_next = scan_reg;
        res_next = res_reg;
        out_load = 1'b0;
        case (state_reg)
            ucrr_pkg::B_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop = 1'b1;
                    res_next = '{action: ucrr_pkg::ACT_REPLY, len: 8'd0,
                                 src: ucrr_pkg::SRC_ZERO, slot: 3'd0};
                    case (cmd.op)
                        ucrr_pkg::OP_LOAD:
                        begin
                            // Loads beyond the table are dropped.
                            tbl_we = (int'(cmd.slot) < ucrr_pkg::TABLE_DEPTH);
                            res_next.action = ucrr_pkg::ACT_NONE;
                        end
                        ucrr_pkg::OP_BUS_RESET:
                        begin
                            addr_next = 7'd0;
                            res_next.action = ucrr_pkg::ACT_NONE;
                        end
                        ucrr_pkg::OP_STATUS: res_next.len = 8'd0;
                        ucrr_pkg::OP_GET_STATUS: res_next.len = 8'd2;
                        ucrr_pkg::OP_SET_ADDR: addr_next = cmd.value[6:0] & ucrr_pkg::ADDR_MASK;
                        ucrr_pkg::OP_SET_CONFIG: cfg_next = cmd.value[7:0];
                        ucrr_pkg::OP_GET_CONFIG:
                        begin
                            res_next.len = 8'd1;
                            res_next.src = ucrr_pkg::SRC_CONFIG;
                        end
                        ucrr_pkg::OP_GET_REPORT: res_next.len = 8'(ucrr_pkg::REPORT_BYTES);
                        ucrr_pkg::OP_STALL: res_next.action = ucrr_pkg::ACT_STALL;
                        ucrr_pkg::OP_GET_DESC:
                        begin
                            // Scan from the top down so the first hit is the last match.
                            scan_next = ucrr_pkg::SLOT_W'(ucrr_pkg::TABLE_DEPTH - 1);
                        end
                        default: res_next.action = ucrr_pkg::ACT_NONE;
                    endcase
                end
            end
            ucrr_pkg::B_SCAN:
            begin
                if (scan_hit)
                begin
                    res_next.action = ucrr_pkg::ACT_REPLY;
                    res_next.src = ucrr_pkg::SRC_DESC;
                    res_next.slot = 3'(scan_reg);
                    res_next.len = ({8'd0, scan_entry.length} > key_length_reg)
                                 ? key_length_reg[7:0] : scan_entry.length;
                end
                else if (scan_last)
                begin
                    res_next = '{action: ucrr_pkg::ACT_STALL, len: 8'd0,
                                 src: ucrr_pkg::SRC_ZERO, slot: 3'd0};
                end
                else
                begin
                    scan_next = scan_reg - 1'b1;
                end
            end
            ucrr_pkg::B_DONE:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default: cmd_pop = 1'b0;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (tbl_we)
        begin
            valid_next[tbl_slot] = 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ucrr_pkg::B_IDLE;
            valid_reg <= '0;
            addr_reg <= 7'd0;
            cfg_reg <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            addr_reg <= addr_next;
            cfg_reg <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            keys_reg[tbl_slot] <= '{value: cmd.value, index: cmd.index,
                                    length: cmd.entry_length};
        end
        if (cmd_pop)
        begin
            key_value_reg <= cmd.value;
            key_index_reg <= cmd.index;
            key_length_reg <= cmd.length;
        end
        scan_reg <= scan_next;
        res_reg <= res_next;
        if (out_load)
        begin
            out_user_reg <= res_reg.action;
            out_data_reg <= {4'd0, cfg_reg, addr_reg, res_reg.slot, res_reg.src, res_reg.len};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;
    assign out_user = out_user_reg;

endmodule

`default_nettype wire

// ===== rtl/usb_control_request_responder.sv =====
// Top level of the USB control request responder: front decoder, command
// queue and back executor. Depends on ucrr_pkg, ucrr_front, ucrr_cmd_fifo, ucrr_back.
//
// The block answers setup packets on the default control pipe. Each input word
// on the s_axis side is a descriptor table load, a setup packet or a bus reset,
// selected by tuser. Every input word yields exactly one result word on the
// m_axis side, in order; tuser carries the action (none, reply, stall) and tdata
// carries the reply length, its source, the descriptor slot, and the device
// address and configuration as they stand after that word.
// The front decodes the request and writes a command into a two-entry queue, so
// the input side keeps accepting while the back is busy or the sink stalls.
// The back takes one command at a time and pops the next only once the last result
// is loaded into the output register. A plain request passes from the queue to the
// result register and then to the output register. Get descriptor walks the eight-entry
// key table one slot per cycle from the top, stopping at the first hit or, with no hit,
// stalling after slot zero, before its result is registered.
// When the sink holds tready low the result stays in the output register, the
// back waits with the next result, and the queue fills before s_axis_tready drops.
// Reset clears the queue, the table's valid bits, the address and the
// configuration; no result is pending after reset.
`default_nettype none

module usb_control_request_responder (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [2:0] entry_slot, [10:3] entry_length, [18:11] request_type,
    // [26:19] request_code, [42:27] request_value, [58:43] request_index,
    // [74:59] request_length, [79:75] zero
    input  wire logic [ucrr_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [1:0] func
    input  wire logic [ucrr_pkg::IN_USER_W-1:0]      s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [7:0] reply_length, [9:8] reply_source, [12:10] reply_slot,
    // [19:13] device_address, [27:20] active_configuration, [31:28] zero
    output logic [ucrr_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
    // [1:0] action
    output logic [ucrr_pkg::OUT_USER_W-1:0]          m_axis_tuser
);

    ucrr_pkg::cmd_t front_cmd;
    ucrr_pkg::cmd_t head_cmd;
    logic fifo_full;
    logic fifo_empty;
    logic back_pop;

    ucrr_front u_front (
        .in_data (s_axis_tdata),
        .in_user (s_axis_tuser),
        .cmd     (front_cmd)
    );

    // An input word is accepted whenever the queue has room.
    assign s_axis_tready = !fifo_full;

    ucrr_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (s_axis_tvalid),
        .push_cmd (front_cmd),
        .full     (fifo_full),
        .pop      (back_pop),
        .head_cmd (head_cmd),
        .empty    (fifo_empty)
    );

    ucrr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_empty (fifo_empty),
        .cmd_pop   (back_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ===== rtl/ucrr_checker.sv =====
// Port-level checker for the USB control request responder, bound to the top.
// Depends on ucrr_pkg.
`default_nettype none

module ucrr_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [ucrr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input wire logic [ucrr_pkg::OUT_USER_W-1:0]   m_axis_tuser
);

    // A stalled result word stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word withdrawn while stalled");

    // A stalled result word keeps its contents.
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // Without a reply, the length, source and slot fields read zero.
    a_no_reply_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != ucrr_pkg::ACT_REPLY) |-> (m_axis_tdata[12:0] == '0))
        else $error("reply fields set on a result with no reply");

    // A configuration byte reply is always one byte long.
    a_config_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[9:8] == ucrr_pkg::SRC_CONFIG)
        |-> (m_axis_tdata[7:0] == 8'd1) && (m_axis_tuser == ucrr_pkg::ACT_REPLY))
        else $error("configuration reply with wrong length or action");

    // Only descriptor replies name a slot.
    a_slot_src: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[9:8] != ucrr_pkg::SRC_DESC) |-> (m_axis_tdata[12:10] == '0))
        else $error("slot set on a non-descriptor reply");

endmodule

bind usb_control_request_responder ucrr_checker u_ucrr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
